[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SSL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ssl_pkg.sv]
// Types, codes and the per-bit step function of the strobed serial link master.
package ssl_pkg;

	localparam int MAX_BYTES_DEF = 16;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LEAD = 6'b000010,
		ST_CMD  = 6'b000100,
		ST_GAP  = 6'b001000,
		ST_DATA = 6'b010000,
		ST_TAIL = 6'b100000
	} stage_t;

	localparam logic [1:0] PH_DRIVE  = 2'd0;
	localparam logic [1:0] PH_SAMPLE = 2'd1;
	localparam logic [1:0] PH_RISE   = 2'd2;
	localparam logic [1:0] PH_GUARD  = 2'd3;

	localparam logic [1:0] MODE_CMD   = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic       start_req;
		logic [1:0] op;
		logic [7:0] command;
		logic [4:0] length;
		logic [7:0] wr_data;
		logic       dio_in;
	} item_t;

	typedef struct packed {
		logic       stb;
		logic       clk_res;
		logic       dio_out;
		logic       dio_drive;
		logic       take_data;
		logic [7:0] rd_data;
		logic       rd_valid;
		logic       busy_res;
		logic       done_res;
	} result_t;

	typedef struct packed {
		stage_t     stage;
		logic [1:0] tick_phase;
		logic [2:0] bit_index;
		logic [7:0] shift_byte;
		logic [1:0] mode;
		logic       guard_count;
		logic       stb;
		logic       clk;
		logic       dio;
		logic       drv;
	} core_state_t;

	localparam core_state_t STATE_RST = '{
		stage: ST_IDLE, tick_phase: PH_DRIVE, bit_index: 3'd0, shift_byte: 8'd0,
		mode: MODE_CMD, guard_count: 1'b0, stb: 1'b1, clk: 1'b1, dio: 1'b0, drv: 1'b1
	};

	typedef struct packed {
		core_state_t s;
		logic        fin;
		logic        rdv;
		logic [7:0]  rdd;
	} bit_res_t;

	// One tick of a bit: drive/release, clock low or sample, clock high.
	function automatic bit_res_t bit_tick(core_state_t s, logic reading, logic din);
		bit_res_t r;
		r.s   = s;
		r.fin = 1'b0;
		r.rdv = 1'b0;
		r.rdd = 8'd0;
		if (s.tick_phase == PH_DRIVE) begin
			if (reading) begin
				r.s.drv = 1'b0;
				r.s.clk = 1'b0;
			end else begin
				r.s.drv = 1'b1;
				r.s.dio = s.shift_byte[s.bit_index];
			end
			r.s.tick_phase = PH_SAMPLE;
		end else if (s.tick_phase == PH_SAMPLE) begin
			if (reading) begin
				if (din)
					r.s.shift_byte[s.bit_index] = 1'b1;
				if (s.bit_index == LAST_BIT) begin
					r.rdv = 1'b1;
					r.rdd = r.s.shift_byte;
				end
			end else begin
				r.s.clk = 1'b0;
			end
			r.s.tick_phase = PH_RISE;
		end else begin
			r.s.clk = 1'b1;
			if (s.bit_index == LAST_BIT) begin
				r.s.bit_index = 3'd0;
				r.fin = 1'b1;
			end else begin
				r.s.bit_index  = s.bit_index + 3'd1;
				r.s.tick_phase = PH_DRIVE;
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/ssl_seq.sv]
// Transaction sequencer: link state registers and the one-tick step logic.
module ssl_seq import ssl_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	output result_t res
);

	localparam int BL_W = $clog2(MAX_BYTES + 1);
	localparam int CW   = (BL_W > 5) ? BL_W : 5;

	core_state_t     st_q, nx;
	logic [BL_W-1:0] bl_q, nbl;

	core_state_t     ds, bs, dt;
	logic [BL_W-1:0] dbl;
	logic            dtake, drdv, reading;
	logic [7:0]      drdd;
	bit_res_t        dbr, cbr;
	logic [CW-1:0]   len_w, sat_w;

	assign len_w = CW'(item.length);
	assign sat_w = (len_w > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : len_w;

	// data tick, also used for the first data tick straight out of the gap
	always_comb begin
		ds = st_q;
		if (st_q.stage == ST_GAP) begin
			ds.stage      = ST_DATA;
			ds.tick_phase = PH_DRIVE;
			ds.bit_index  = 3'd0;
		end
		reading = (ds.mode == MODE_READ);
		dt      = ds;
		dbl     = bl_q;
		dtake   = 1'b0;
		drdv    = 1'b0;
		drdd    = 8'd0;
		bs      = ds;
		dbr     = '0;
		if (ds.tick_phase == PH_GUARD) begin
			dt.stage       = ST_TAIL;
			dt.guard_count = 1'b0;
			dt.tick_phase  = PH_DRIVE;
		end else begin
			if (ds.tick_phase == PH_DRIVE && ds.bit_index == 3'd0) begin
				if (reading) begin
					bs.shift_byte = 8'd0;
				end else begin
					bs.shift_byte = item.wr_data;
					dtake         = 1'b1;
				end
			end
			dbr  = bit_tick(bs, reading, item.dio_in);
			dt   = dbr.s;
			drdv = dbr.rdv;
			drdd = dbr.rdd;
			if (dbr.fin) begin
				if (dbl != '0)
					dbl = dbl - BL_W'(1);
				dt.tick_phase = (dbl != '0) ? PH_DRIVE : PH_GUARD;
			end
		end
	end

	assign cbr = bit_tick(st_q, 1'b0, item.dio_in);

	always_comb begin
		nx            = st_q;
		nbl           = bl_q;
		res           = '0;
		unique case (st_q.stage)
			ST_LEAD: begin
				nx.stage      = ST_CMD;
				nx.tick_phase = PH_DRIVE;
				nx.bit_index  = 3'd0;
			end
			ST_CMD: begin
				if (st_q.tick_phase == PH_GUARD) begin
					nx.stage       = ST_GAP;
					nx.guard_count = 1'b0;
					nx.tick_phase  = PH_DRIVE;
				end else begin
					nx = cbr.s;
					if (cbr.fin)
						nx.tick_phase = PH_GUARD;
				end
			end
			ST_GAP: begin
				if (!st_q.guard_count) begin
					nx.guard_count = 1'b1;
				end else if (st_q.mode == MODE_CMD) begin
					nx.stb         = 1'b1;
					nx.stage       = ST_IDLE;
					nx.tick_phase  = PH_DRIVE;
					nx.guard_count = 1'b0;
					res.done_res   = 1'b1;
				end else if (bl_q != '0) begin
					nx            = dt;
					nbl           = dbl;
					res.take_data = dtake;
					res.rd_valid  = drdv;
					res.rd_data   = drdd;
				end else begin
					nx.stage       = ST_TAIL;
					nx.guard_count = 1'b0;
				end
			end
			ST_DATA: begin
				nx            = dt;
				nbl           = dbl;
				res.take_data = dtake;
				res.rd_valid  = drdv;
				res.rd_data   = drdd;
			end
			ST_TAIL: begin
				if (!st_q.guard_count) begin
					nx.guard_count = 1'b1;
				end else begin
					nx.stb         = 1'b1;
					nx.stage       = ST_IDLE;
					nx.tick_phase  = PH_DRIVE;
					nx.guard_count = 1'b0;
					res.done_res   = 1'b1;
				end
			end
			default: begin
				nx.stage = ST_IDLE;
				if (item.start_req) begin
					nx.mode = (item.op == MODE_WRITE || item.op == MODE_READ) ?
						item.op : MODE_CMD;
					nx.shift_byte  = item.command;
					nbl            = sat_w[BL_W-1:0];
					nx.tick_phase  = PH_DRIVE;
					nx.bit_index   = 3'd0;
					nx.guard_count = 1'b0;
					nx.stb         = 1'b0;
					nx.stage       = ST_LEAD;
				end
			end
		endcase
		res.stb       = nx.stb;
		res.clk_res   = nx.clk;
		res.dio_out   = nx.dio;
		res.dio_drive = nx.drv;
		res.busy_res  = (nx.stage != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
			bl_q <= '0;
		end else if (step_en) begin
			st_q <= nx;
			bl_q <= nbl;
		end
	end

endmodule

[hw/rtl/strobed_serial_link_master.sv]
// Strobed three-wire serial link master, top level with input and result registers.
//
// Input channel (in_valid/in_stall): one word per timer tick with the start
// request fields, the offered write byte and the sampled data pin.
// Output channel (out_valid/out_stall): one word per input word with the line
// levels after that tick, the write-byte take strobe, a received byte with
// its valid flag, and busy/done flags.
// An accepted word goes from the input register through one sequencer step
// into the result register. Throughput: one word per cycle while out_stall
// is low; the sequencer advances one phase per word. A transaction is: strobe
// low, one idle tick, eight command bits of three ticks each, two idle ticks,
// for a read or write length data bytes (max MAX_BYTES), two idle ticks; strobe high.
// Reset: sequencer idle, strobe and clock high, data line driven low, both
// pipeline slots empty.
// Receiver stall: the result register holds; the input register holds one
// more word; in_stall rises only when both are full and out_stall is high.
module strobed_serial_link_master import ssl_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       start_req,
	input  logic [1:0] op,
	input  logic [7:0] command,
	input  logic [4:0] length,
	input  logic [7:0] wr_data,
	input  logic       dio_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       stb,
	output logic       clk_res,
	output logic       dio_out,
	output logic       dio_drive,
	output logic       take_data,
	output logic [7:0] rd_data,
	output logic       rd_valid,
	output logic       busy_res,
	output logic       done_res
);

	logic    valid_s1, out_valid_q, adv, step_en, in_acc;
	item_t   item_s1;
	result_t res_d, res_q;

	assign adv      = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			item_s1 <= '{start_req, op, command, length, wr_data, dio_in};
	end

	ssl_seq #(
		.MAX_BYTES(MAX_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign stb       = res_q.stb;
	assign clk_res   = res_q.clk_res;
	assign dio_out   = res_q.dio_out;
	assign dio_drive = res_q.dio_drive;
	assign take_data = res_q.take_data;
	assign rd_data   = res_q.rd_data;
	assign rd_valid  = res_q.rd_valid;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;

endmodule

[hw/rtl/ssl_checker.sv]
// Port-level checker for the strobed serial link master and its bind.
`include "assert_macros.svh"

module ssl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       start_req,
	input logic [1:0] op,
	input logic [7:0] command,
	input logic [4:0] length,
	input logic [7:0] wr_data,
	input logic       dio_in,
	input logic       out_valid,
	input logic       out_stall,
	input logic       stb,
	input logic       clk_res,
	input logic       dio_out,
	input logic       dio_drive,
	input logic       take_data,
	input logic [7:0] rd_data,
	input logic       rd_valid,
	input logic       busy_res,
	input logic       done_res
);

	`SSL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rd_data), "stalled word changed")
	`SSL_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res && stb, "done while busy or strobe low")
	`SSL_ASSERT_NOW(a_idle_lines, out_valid && !busy_res, stb && clk_res, "idle with strobe or clock low")
	`SSL_ASSERT_NOW(a_read_released, out_valid && rd_valid, !dio_drive && busy_res && !stb, "read byte while driving")
	`SSL_ASSERT_NOW(a_take_driven, out_valid && take_data, dio_drive && busy_res && !rd_valid, "write byte taken while released")

endmodule

bind strobed_serial_link_master ssl_checker u_ssl_checker (.*);

[sim/tb.sv]
// Testbench for the strobed serial link master: directed table, random ticks, line-level checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssl_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 1330;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		item_t   w;
		logic    typed;
		result_t res;
	} row_t;

	localparam result_t IDLE_LINES = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
	localparam result_t LOW_STB    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
	localparam result_t BIT0_SET   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
	localparam result_t BIT0_CLKLO = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};

	localparam int PLAN_LEN = 24;
	localparam row_t PLAN [0:PLAN_LEN-1] = '{
		'{'{1'b0, 2'd0, 8'h00, 5'd0,  8'h00, 1'b0}, 1'b1, IDLE_LINES},
		'{'{1'b0, 2'd3, 8'hFF, 5'd31, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
		'{'{1'b1, 2'd3, 8'hFF, 5'd31, 8'hFF, 1'b1}, 1'b1, LOW_STB},
		'{'{1'b1, 2'd1, 8'h00, 5'd16, 8'h00, 1'b0}, 1'b1, LOW_STB},
		'{'{1'b1, 2'd2, 8'h5A, 5'd1,  8'hFF, 1'b1}, 1'b1, BIT0_SET},
		'{'{1'b0, 2'd0, 8'hA5, 5'd0,  8'h00, 1'b0}, 1'b1, BIT0_CLKLO},
		'{'{1'b1, 2'd1, 8'h80, 5'd17, 8'h01, 1'b1}, 1'b1, BIT0_SET},
		'{'{1'b1, 2'd2, 8'h01, 5'd8,  8'h80, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd3, 8'h7F, 5'd4,  8'h7F, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd0, 8'hFE, 5'd2,  8'hFE, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd1, 8'h55, 5'd31, 8'h55, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd2, 8'hAA, 5'd16, 8'hAA, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd3, 8'h0F, 5'd15, 8'h0F, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd1, 8'hF0, 5'd0,  8'hF0, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd2, 8'h33, 5'd1,  8'h33, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd0, 8'hCC, 5'd3,  8'hCC, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd1, 8'hFF, 5'd31, 8'hFF, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd3, 8'h00, 5'd0,  8'h00, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd2, 8'h12, 5'd5,  8'h34, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd1, 8'h56, 5'd6,  8'h78, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd0, 8'h9A, 5'd7,  8'hBC, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd2, 8'hDE, 5'd9,  8'hF0, 1'b1}, 1'b0, IDLE_LINES},
		'{'{1'b0, 2'd3, 8'h11, 5'd10, 8'h22, 1'b0}, 1'b0, IDLE_LINES},
		'{'{1'b1, 2'd1, 8'h44, 5'd12, 8'h88, 1'b1}, 1'b0, IDLE_LINES}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       start_req;
	logic [1:0] op;
	logic [7:0] command;
	logic [4:0] length;
	logic [7:0] wr_data;
	logic       dio_in;
	logic       out_valid;
	logic       out_stall;
	logic       stb;
	logic       clk_res;
	logic       dio_out;
	logic       dio_drive;
	logic       take_data;
	logic [7:0] rd_data;
	logic       rd_valid;
	logic       busy_res;
	logic       done_res;

	strobed_serial_link_master dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_req(start_req), .op(op), .command(command), .length(length),
		.wr_data(wr_data), .dio_in(dio_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.stb(stb), .clk_res(clk_res), .dio_out(dio_out), .dio_drive(dio_drive),
		.take_data(take_data), .rd_data(rd_data), .rd_valid(rd_valid),
		.busy_res(busy_res), .done_res(done_res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sequencer copy
	stage_t     seq_stage;
	logic [1:0] seq_phase;
	logic [2:0] seq_bit;
	logic [4:0] seq_left;
	logic [7:0] seq_shift;
	logic [1:0] seq_mode;
	logic       seq_guard;
	logic       ln_stb, ln_clk, ln_dio, ln_drv;
	logic       tk_take, tk_rdv, tk_done;
	logic [7:0] tk_rdd;

	result_t levels_due [$];
	result_t want;
	int      mismatches = 0;
	int      cycles = 0;
	int      rx_cycles = 0;
	logic    steady = 1'b0;

	function automatic logic shift_bit(logic reading, logic din);
		if (seq_phase == PH_DRIVE) begin
			if (reading) begin
				ln_drv = 1'b0;
				ln_clk = 1'b0;
			end else begin
				ln_drv = 1'b1;
				ln_dio = seq_shift[seq_bit];
			end
			seq_phase = PH_SAMPLE;
		end else if (seq_phase == PH_SAMPLE) begin
			if (reading) begin
				if (din)
					seq_shift[seq_bit] = 1'b1;
				if (seq_bit == LAST_BIT) begin
					tk_rdv = 1'b1;
					tk_rdd = seq_shift;
				end
			end else begin
				ln_clk = 1'b0;
			end
			seq_phase = PH_RISE;
		end else begin
			ln_clk = 1'b1;
			if (seq_bit == LAST_BIT) begin
				seq_bit = 3'd0;
				return 1'b1;
			end
			seq_bit = seq_bit + 3'd1;
			seq_phase = PH_DRIVE;
		end
		return 1'b0;
	endfunction

	function automatic void data_byte_tick(logic [7:0] wr, logic din);
		logic reading;
		reading = (seq_mode == MODE_READ);
		if (seq_phase == PH_GUARD) begin
			seq_stage = ST_TAIL;
			seq_guard = 1'b0;
			seq_phase = PH_DRIVE;
			return;
		end
		if (seq_phase == PH_DRIVE && seq_bit == 3'd0) begin
			if (reading) begin
				seq_shift = 8'd0;
			end else begin
				seq_shift = wr;
				tk_take = 1'b1;
			end
		end
		if (shift_bit(reading, din)) begin
			if (seq_left > 5'd0)
				seq_left = seq_left - 5'd1;
			seq_phase = (seq_left > 5'd0) ? PH_DRIVE : PH_GUARD;
		end
	endfunction

	function automatic void raise_strobe();
		ln_stb = 1'b1;
		seq_stage = ST_IDLE;
		seq_phase = PH_DRIVE;
		seq_guard = 1'b0;
		tk_done = 1'b1;
	endfunction

	function automatic result_t link_tick(item_t w);
		result_t r;
		tk_take = 1'b0;
		tk_rdv = 1'b0;
		tk_rdd = 8'd0;
		tk_done = 1'b0;
		case (seq_stage)
			ST_LEAD: begin
				seq_stage = ST_CMD;
				seq_phase = PH_DRIVE;
				seq_bit = 3'd0;
			end
			ST_CMD: begin
				if (seq_phase == PH_GUARD) begin
					seq_stage = ST_GAP;
					seq_guard = 1'b0;
					seq_phase = PH_DRIVE;
				end else if (shift_bit(1'b0, w.dio_in)) begin
					seq_phase = PH_GUARD;
				end
			end
			ST_GAP: begin
				if (!seq_guard) begin
					seq_guard = 1'b1;
				end else if (seq_mode == MODE_CMD) begin
					raise_strobe();
				end else if (seq_left > 5'd0) begin
					seq_stage = ST_DATA;
					seq_phase = PH_DRIVE;
					seq_bit = 3'd0;
					data_byte_tick(w.wr_data, w.dio_in);
				end else begin
					seq_stage = ST_TAIL;
					seq_guard = 1'b0;
				end
			end
			ST_DATA: data_byte_tick(w.wr_data, w.dio_in);
			ST_TAIL: begin
				if (!seq_guard)
					seq_guard = 1'b1;
				else
					raise_strobe();
			end
			default: begin
				seq_stage = ST_IDLE;
				if (w.start_req) begin
					seq_mode = (w.op == OP_SPARE) ? MODE_CMD : w.op;
					seq_shift = w.command;
					seq_left = (w.length > MAX_BYTES_DEF) ? 5'(MAX_BYTES_DEF) : w.length;
					seq_phase = PH_DRIVE;
					seq_bit = 3'd0;
					seq_guard = 1'b0;
					ln_stb = 1'b0;
					seq_stage = ST_LEAD;
				end
			end
		endcase
		r.stb = ln_stb;
		r.clk_res = ln_clk;
		r.dio_out = ln_dio;
		r.dio_drive = ln_drv;
		r.take_data = tk_take;
		r.rd_data = tk_rdd;
		r.rd_valid = tk_rdv;
		r.busy_res = (seq_stage != ST_IDLE);
		r.done_res = tk_done;
		return r;
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic put_word(item_t w, logic typed, result_t typed_res);
		int idle;
		result_t guess;
		idle = steady ? 0 : pick_idle();
		@(negedge clk);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		start_req <= w.start_req;
		op <= w.op;
		command <= w.command;
		length <= w.length;
		wr_data <= w.wr_data;
		dio_in <= w.dio_in;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		guess = link_tick(w);
		levels_due.push_back(typed ? typed_res : guess);
	endtask

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (levels_due.size() == 0) begin
				$error("result word with nothing pending");
				mismatches++;
			end else begin
				want = levels_due.pop_front();
				check_field("stb", want.stb, stb);
				check_field("clk_res", want.clk_res, clk_res);
				check_field("dio_out", want.dio_out, dio_out);
				check_field("dio_drive", want.dio_drive, dio_drive);
				check_field("take_data", want.take_data, take_data);
				check_field("rd_data", want.rd_data, rd_data);
				check_field("rd_valid", want.rd_valid, rd_valid);
				check_field("busy_res", want.busy_res, busy_res);
				check_field("done_res", want.done_res, done_res);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int hold;
		logic long_done;
		out_stall = 1'b0;
		hold = 0;
		long_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (hold == 0) begin
				if (!long_done && rx_cycles >= 900) begin
					hold = 300;
					long_done = 1'b1;
				end else if (rx_cycles % 1000 < 150) begin
					hold = 0;
				end else begin
					hold = pick_idle();
				end
			end
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	initial begin
		item_t w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_req = 1'b0;
		op = 2'd0;
		command = 8'd0;
		length = 5'd0;
		wr_data = 8'd0;
		dio_in = 1'b0;
		seq_stage = ST_IDLE;
		seq_phase = PH_DRIVE;
		seq_bit = 3'd0;
		seq_left = 5'd0;
		seq_shift = 8'd0;
		seq_mode = MODE_CMD;
		seq_guard = 1'b0;
		ln_stb = 1'b1;
		ln_clk = 1'b1;
		ln_dio = 1'b0;
		ln_drv = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_LEN; i++)
			put_word(PLAN[i].w, PLAN[i].typed, PLAN[i].res);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady = (n >= 300 && n < 450);
			if (n == 1000) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (levels_due.size() != 0)
					@(negedge clk);
			end
			if (seq_stage != ST_IDLE)
				w.start_req = 1'($urandom_range(0, 1));
			else
				w.start_req = ($urandom_range(0, 3) != 0);
			w.op = 2'($urandom_range(0, 3));
			w.command = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 11) == 0)
				w.length = 5'($urandom_range(0, 31));
			else
				w.length = 5'($urandom_range(0, 3));
			w.wr_data = 8'($urandom_range(0, 255));
			w.dio_in = 1'($urandom_range(0, 1));
			put_word(w, 1'b0, IDLE_LINES);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
